FILE: rtl/bidt_pkg.sv
`default_nettype none

package bidt_pkg;

    typedef enum logic
    {
        OP_RECORD = 1'b0,
        OP_CHECK  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_STALE    = 2'd0,
        ST_SAME     = 2'd1,
        ST_RECORDED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // A check word always reports status code zero.
    localparam status_t ST_NONE = ST_STALE;

    // Request word as it travels down the row of cells, with what has been learned so far.
    typedef struct packed
    {
        logic        done;
        logic        found;
        status_t     status;
        logic [31:0] stored;
        op_t         op;
        logic [31:0] addr;
        logic [31:0] rid;
    } token_t;

endpackage

`default_nettype wire

FILE: rtl/broadcast_id_duplicate_table_top.sv
`default_nettype none

// Route-request duplicate table built as a row of TABLE_ENTRIES cells, each holding one
// source address and its latest broadcast id. An accepted word walks the row one cell
// per clock; the matching cell answers or updates itself, and the first empty cell takes
// a new source on a record. The result passes a hold register and then an output register.
// One word is in the row at a time: no new word is accepted until the result of the last
// has moved to the output register, so the length of the cell row bounds the rate. A record
// of an unknown source with every cell occupied reports table full. Reset empties the table.

module broadcast_id_duplicate_table_top
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] request_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic             duplicate,
    output logic             found,
    output logic [31:0]      stored_id
);

    logic                 in_flight_reg;
    logic                 accept;
    logic                 chain_active [TABLE_ENTRIES + 1];
    bidt_pkg::token_t     chain_tok    [TABLE_ENTRIES + 1];
    logic [TABLE_ENTRIES - 1:0] active_vec;

    bidt_pkg::token_t     tail_tok;
    logic                 tail_active;

    logic                 hold_valid_reg;
    logic [1:0]           hold_status_reg;
    logic                 hold_dup_reg;
    logic                 hold_found_reg;
    logic [31:0]          hold_stored_reg;
    logic                 res_dup;
    bidt_pkg::status_t    res_status;
    logic                 move;

    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic                 out_dup_reg;
    logic                 out_found_reg;
    logic [31:0]          out_stored_reg;

    assign in_stall = in_flight_reg;
    assign accept   = in_valid && !in_flight_reg;

    assign chain_active[0]     = accept;
    assign chain_tok[0].done   = 1'b0;
    assign chain_tok[0].found  = 1'b0;
    assign chain_tok[0].status = bidt_pkg::ST_NONE;
    assign chain_tok[0].stored = 32'd0;
    assign chain_tok[0].op     = bidt_pkg::op_t'(opcode);
    assign chain_tok[0].addr   = source_address;
    assign chain_tok[0].rid    = request_id;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            bidt_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_active  (chain_active[gi]),
                .in_tok     (chain_tok[gi]),
                .out_active (chain_active[gi + 1]),
                .out_tok    (chain_tok[gi + 1])
            );
            assign active_vec[gi] = chain_active[gi + 1];
        end
    endgenerate

    assign tail_active = chain_active[TABLE_ENTRIES];
    assign tail_tok    = chain_tok[TABLE_ENTRIES];

    // A word that leaves the row unanswered met no match and no empty cell.
    always_comb
    begin
        if (tail_tok.done)
        begin
            res_status = tail_tok.status;
        end
        else if (tail_tok.op == bidt_pkg::OP_RECORD)
        begin
            res_status = bidt_pkg::ST_FULL;
        end
        else
        begin
            res_status = bidt_pkg::ST_NONE;
        end
        res_dup = tail_tok.done && tail_tok.found && (tail_tok.rid <= tail_tok.stored);
    end

    assign move = hold_valid_reg && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_flight_reg <= 1'b1;
            end
            else if (move)
            begin
                in_flight_reg <= 1'b0;
            end

            if (tail_active)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_active)
        begin
            hold_status_reg <= res_status;
            hold_dup_reg    <= res_dup;
            hold_found_reg  <= tail_tok.done && tail_tok.found;
            hold_stored_reg <= tail_tok.done ? tail_tok.stored : 32'd0;
        end
        if (move)
        begin
            out_status_reg <= hold_status_reg;
            out_dup_reg    <= hold_dup_reg;
            out_found_reg  <= hold_found_reg;
            out_stored_reg <= hold_stored_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign duplicate = out_dup_reg;
    assign found     = out_found_reg;
    assign stored_id = out_stored_reg;

    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(active_vec))
        else $error("more than one word in the cell row");

    a_tail_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tail_active |-> (in_flight_reg && !hold_valid_reg))
        else $error("word left the row with nothing in flight or hold stage busy");

    a_enter_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> chain_active[1])
        else $error("accepted word did not enter the first cell");

    a_hold_flight: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> in_flight_reg)
        else $error("result held with no word in flight");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == bidt_pkg::ST_FULL)) |-> !out_found_reg)
        else $error("table full reported for a known source");

endmodule

`default_nettype wire

FILE: rtl/bidt_cell.sv
`default_nettype none

module bidt_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_active,
    input  wire bidt_pkg::token_t in_tok,
    output logic                 out_active,
    output bidt_pkg::token_t     out_tok
);

    logic              valid_reg;
    logic              valid_next;
    logic [31:0]       addr_reg;
    logic [31:0]       addr_next;
    logic [31:0]       id_reg;
    logic [31:0]       id_next;
    logic              active_reg;
    bidt_pkg::token_t  tok_reg;
    bidt_pkg::token_t  tok_next;
    logic              hit;

    assign hit = valid_reg && (addr_reg == in_tok.addr);

    // Entries fill from the lowest cell up and are never freed, so the first empty
    // cell a word reaches lies past every occupied one: the lookup is complete there.
    always_comb
    begin
        tok_next   = in_tok;
        valid_next = valid_reg;
        addr_next  = addr_reg;
        id_next    = id_reg;
        if (in_active && !in_tok.done)
        begin
            if (hit)
            begin
                tok_next.done   = 1'b1;
                tok_next.found  = 1'b1;
                tok_next.stored = id_reg;
                if (in_tok.op == bidt_pkg::OP_RECORD)
                begin
                    if (id_reg > in_tok.rid)
                    begin
                        tok_next.status = bidt_pkg::ST_STALE;
                    end
                    else if (id_reg == in_tok.rid)
                    begin
                        tok_next.status = bidt_pkg::ST_SAME;
                    end
                    else
                    begin
                        tok_next.status = bidt_pkg::ST_RECORDED;
                        id_next         = in_tok.rid;
                    end
                end
                else
                begin
                    tok_next.status = bidt_pkg::ST_NONE;
                end
            end
            else if (!valid_reg)
            begin
                tok_next.done   = 1'b1;
                tok_next.found  = 1'b0;
                tok_next.stored = 32'd0;
                if (in_tok.op == bidt_pkg::OP_RECORD)
                begin
                    tok_next.status = bidt_pkg::ST_RECORDED;
                    valid_next      = 1'b1;
                    addr_next       = in_tok.addr;
                    id_next         = in_tok.rid;
                end
                else
                begin
                    tok_next.status = bidt_pkg::ST_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= in_active;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        id_reg   <= id_next;
        tok_reg  <= tok_next;
    end

    assign out_active = active_reg;
    assign out_tok    = tok_reg;

endmodule

`default_nettype wire
